// ===== src/assert_macros.svh =====
// assertion macros for the rtl, included by svpwm_duty_generator_core
// expects signals named clk and rst in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant");
`define ASSERT_IMPLIES(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed: implication");
`else
`define ASSERT_ALWAYS(name, cond)
`define ASSERT_IMPLIES(name, pre, post)
`endif
`endif

// ===== src/svpwm_pkg.sv =====
// shared constants and register codes for the svpwm duty generator
// no dependencies
`default_nettype none
package svpwm_pkg;

  parameter int SVPWM_VOLTAGE_BITS = 16;
  parameter int SVPWM_PERIOD_BITS  = 16;

  localparam int LIMIT_BITS   = 16;
  localparam int QUO_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd62259;
  localparam int MIN_BUS        = 26;
  localparam int INV_SQRT3_Q16  = 37837;
  localparam int SQRT3_HALF_Q16 = 56756;
  localparam int HALF_Q16       = 32768;
  localparam int ONE_Q16        = 65536;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MOD_LIMIT  = 2'd0,
    REG_PWM_PERIOD = 2'd1
  } cfg_reg_t;

endpackage
`default_nettype wire

// ===== src/svpwm_duty_generator_core.sv =====
// svpwm duty generator top level: magnitude limit, inverse clarke, min-max injection
// depends on svpwm_pkg, svpwm_div and assert_macros.svh
//
// usage:
//   s_tdata carries one alpha/beta/bus request per accepted beat; m_tdata returns the
//   three compare counts and m_tuser[0] says whether they are valid (ok)
//   cfg writes modulation_limit (index 0) and pwm_period (index 1); other indexes
//   are ignored; cfg_ready is always high
// depth: set by the one-bit-per-stage square root and the two sixteen-stage
//   quotient pipelines
// throughput: one request per cycle while s_tready is high, every stage is registered and free of feedback
// reset: all valid bits clear, modulation_limit = 62259, pwm_period = 0
// stall: a skid register behind the output register takes one more result while
//   m_tready is low; once it is full s_tready drops and the whole pipeline holds
//   in place, nothing is dropped or repeated
// bus below 0.1 V or a zero period gives three zero counts and ok low
`default_nettype none
`include "assert_macros.svh"
module svpwm_duty_generator_core
  import svpwm_pkg::*;
#(
  parameter int VOLTAGE_BITS = SVPWM_VOLTAGE_BITS,
  parameter int PERIOD_BITS  = SVPWM_PERIOD_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // alpha_voltage, beta_voltage, bus_voltage from bit 0 up, zero padded to bytes
  input  logic [((3*VOLTAGE_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // u_compare, v_compare, w_compare from bit 0 up, zero padded to bytes
  output logic [((3*PERIOD_BITS+7)/8)*8-1:0] m_tdata,
  // ok
  output logic [0:0] m_tuser,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [((PERIOD_BITS > LIMIT_BITS) ? PERIOD_BITS : LIMIT_BITS)-1:0] cfg_data
);

  localparam int V     = VOLTAGE_BITS;
  localparam int P     = PERIOD_BITS;
  localparam int PW    = V + 18;
  localparam int DW    = V + 20;
  localparam int NW    = V + 19;
  localparam int OUT_W = ((3*P+7)/8)*8;

  typedef struct packed {
    logic signed [V-1:0] a;
    logic signed [V-1:0] b;
    logic [V-1:0]        bus;
    logic                bad;
    logic [V-1:0]        vmax;
  } core_t;

  typedef struct packed {
    logic         ok;
    logic [P-1:0] w;
    logic [P-1:0] v;
    logic [P-1:0] u;
  } res_t;

  localparam int CORE_W = $bits(core_t);

  // configuration
  logic [LIMIT_BITS-1:0] mod_limit;
  logic [P-1:0]          pwm_period;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_limit  <= LIMIT_RESET;
      pwm_period <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MOD_LIMIT:  mod_limit  <= cfg_data[LIMIT_BITS-1:0];
        REG_PWM_PERIOD: pwm_period <= cfg_data[P-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v;
  assign en       = !skid_v;
  assign s_tready = en;

  // stage 0: capture request
  logic  v0;
  core_t c0;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
    if (en) begin
      c0.a    <= $signed(s_tdata[V-1:0]);
      c0.b    <= $signed(s_tdata[2*V-1:V]);
      c0.bus  <= s_tdata[3*V-1:2*V];
      c0.bad  <= (s_tdata[3*V-1:2*V] < V'(MIN_BUS)) || (pwm_period == '0);
      c0.vmax <= '0;
    end
  end

  // stage 1: squares and bus * limit
  logic signed [2*V-1:0] a0x, b0x;
  logic                  v1;
  core_t                 c1;
  logic [2*V-1:0]        asq1, bsq1;
  logic [V+15:0]         bl1;
  assign a0x = (2*V)'(c0.a);
  assign b0x = (2*V)'(c0.b);
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
    if (en) begin
      c1   <= c0;
      asq1 <= $unsigned(a0x * a0x);
      bsq1 <= $unsigned(b0x * b0x);
      bl1  <= (V+16)'(c0.bus) * (V+16)'(mod_limit);
    end
  end

  // stage 2: sum of squares and circle radius
  logic [V+15:0]  vm_full;
  core_t          c1m;
  logic           v2;
  core_t          c2;
  logic [2*V-1:0] x2;
  assign vm_full = (V+16)'(bl1[V+15:16]) * (V+16)'(INV_SQRT3_Q16);
  always_comb begin
    c1m      = c1;
    c1m.vmax = vm_full[V+15:16];
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      c2 <= c1m;
      x2 <= asq1 + bsq1;
    end
  end

  // square root, one result bit per stage
  logic [2*V-1:0] sq_rem  [1:V];
  logic [V-1:0]   sq_root [1:V];
  core_t          sq_c    [1:V];
  logic           sq_v    [1:V];

  for (genvar k = 0; k < V; k++) begin : g_sqrt
    localparam int I = V - 1 - k;
    logic [2*V-1:0] rem_in;
    logic [V-1:0]   root_in;
    core_t          c_in;
    logic           v_in;
    logic [2*V:0]   t;
    logic           take;

    if (k == 0) begin : g_first
      assign rem_in  = x2;
      assign root_in = '0;
      assign c_in    = c2;
      assign v_in    = v2;
    end else begin : g_next
      assign rem_in  = sq_rem[k];
      assign root_in = sq_root[k];
      assign c_in    = sq_c[k];
      assign v_in    = sq_v[k];
    end

    assign t    = ((2*V+1)'(root_in) << (I + 1)) + ((2*V+1)'(1) << (2*I));
    assign take = ((2*V+1)'(rem_in) >= t);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= v_in;
      end
      if (en) begin
        sq_rem[k+1]  <= take ? (rem_in - t[2*V-1:0]) : rem_in;
        sq_root[k+1] <= take ? (root_in | (V'(1) << I)) : root_in;
        sq_c[k+1]    <= c_in;
      end
    end
  end

  // scale = vmax * 2^16 / magnitude when the vector is outside the circle
  logic                over3;
  logic                scl_v;
  logic [QUO_BITS-1:0] scl_q;
  logic [CORE_W:0]     scl_side;
  logic                over_d;
  core_t               c_d;

  assign over3 = sq_root[V] > sq_c[V].vmax;

  svpwm_div #(
    .NUM_W  (V + QUO_BITS),
    .DEN_W  (V),
    .SIDE_W (CORE_W + 1)
  ) u_scale_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_v[V]),
    .num       ({sq_c[V].vmax, {QUO_BITS{1'b0}}}),
    .den       (sq_root[V]),
    .side_in   ({over3, sq_c[V]}),
    .out_valid (scl_v),
    .quo       (scl_q),
    .side_out  (scl_side)
  );

  assign {over_d, c_d} = scl_side;

  // stage 4: magnitudes times scale
  logic [V-1:0]  abs_a, abs_b;
  logic          v4, over4;
  core_t         c4;
  logic [V+15:0] pa4, pb4;
  assign abs_a = c_d.a[V-1] ? V'(-c_d.a) : V'(c_d.a);
  assign abs_b = c_d.b[V-1] ? V'(-c_d.b) : V'(c_d.b);
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= scl_v;
    end
    if (en) begin
      c4    <= c_d;
      over4 <= over_d;
      pa4   <= (V+16)'(abs_a) * (V+16)'(scl_q);
      pb4   <= (V+16)'(abs_b) * (V+16)'(scl_q);
    end
  end

  // stage 5: limited vector, truncation toward zero
  logic signed [V-1:0] sa, sb;
  logic                v5;
  core_t               c5;
  logic signed [V-1:0] a5, b5;
  assign sa = $signed(pa4[V+15:16]);
  assign sb = $signed(pb4[V+15:16]);
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      c5 <= c4;
      a5 <= over4 ? (c4.a[V-1] ? -sa : sa) : c4.a;
      b5 <= over4 ? (c4.b[V-1] ? -sb : sb) : c4.b;
    end
  end

  // stage 6: beta * sqrt3/2
  localparam logic signed [PW-1:0] K_SQ3H = PW'(SQRT3_HALF_Q16);
  logic signed [PW-1:0] b5x;
  logic                 v6;
  core_t                c6;
  logic signed [V-1:0]  a6;
  logic signed [PW-1:0] pb6;
  assign b5x = PW'(b5);
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
    if (en) begin
      c6  <= c5;
      a6  <= a5;
      pb6 <= b5x * K_SQ3H;
    end
  end

  // stage 7: inverse clarke, units 2^-24 V
  logic signed [PW-1:0] a6x;
  logic                 v7;
  core_t                c7;
  logic signed [PW-1:0] ph7 [3];
  assign a6x = PW'(a6);
  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
    if (en) begin
      c7     <= c6;
      ph7[0] <= a6x <<< 16;
      ph7[1] <= pb6 - (a6x <<< 15);
      ph7[2] <= -(a6x <<< 15) - pb6;
    end
  end

  // stage 8: min and max of the phases
  logic signed [PW-1:0] lo7, hi7, m01_lo, m01_hi;
  logic                 v8;
  core_t                c8;
  logic signed [PW-1:0] ph8 [3];
  logic signed [PW-1:0] lo8, hi8;
  assign m01_lo = (ph7[1] < ph7[0]) ? ph7[1] : ph7[0];
  assign m01_hi = (ph7[1] > ph7[0]) ? ph7[1] : ph7[0];
  assign lo7    = (ph7[2] < m01_lo) ? ph7[2] : m01_lo;
  assign hi7    = (ph7[2] > m01_hi) ? ph7[2] : m01_hi;
  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
    if (en) begin
      c8  <= c7;
      ph8 <= ph7;
      lo8 <= lo7;
      hi8 <= hi7;
    end
  end

  // stage 9: twice the injected phase voltage
  logic                 v9;
  core_t                c9;
  logic signed [DW-1:0] d9 [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= v8;
    end
    if (en) begin
      c9 <= c8;
      for (int i = 0; i < 3; i++) begin
        d9[i] <= (DW'(ph8[i]) <<< 1) - DW'(lo8) - DW'(hi8);
      end
    end
  end

  // stage 10: floor division set up as unsigned, overflow saturates the duty
  logic [V:0]    den9;
  logic [NW-1:0] n9 [3];
  logic          v10;
  logic          bad10;
  logic [V:0]    den10;
  logic [NW-1:0] n10   [3];
  logic          neg10 [3];
  logic          ovf10 [3];
  assign den9 = {c9.bus, 1'b0};
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n9[i] = d9[i][DW-1] ? ~d9[i][NW-1:0] : d9[i][NW-1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en) begin
      v10 <= v9;
    end
    if (en) begin
      bad10 <= c9.bad;
      den10 <= den9;
      for (int i = 0; i < 3; i++) begin
        n10[i]   <= n9[i];
        neg10[i] <= d9[i][DW-1];
        ovf10[i] <= n9[i] >= NW'({den9, {QUO_BITS{1'b0}}});
      end
    end
  end

  logic                dq_v    [3];
  logic [QUO_BITS-1:0] dq_q    [3];
  logic [2:0]          dq_side [3];

  for (genvar ph = 0; ph < 3; ph++) begin : g_phase
    svpwm_div #(
      .NUM_W  (NW),
      .DEN_W  (V + 1),
      .SIDE_W (3)
    ) u_duty_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v10),
      .num       (n10[ph]),
      .den       (den10),
      .side_in   ({bad10, neg10[ph], ovf10[ph]}),
      .out_valid (dq_v[ph]),
      .quo       (dq_q[ph]),
      .side_out  (dq_side[ph])
    );
  end

  // stage 11: duty in Q1.16, clamped to [0, 1]
  logic [QUO_BITS-1:0] uq [3];
  logic [16:0]         duty_c [3];
  logic                v11, bad11;
  logic [16:0]         duty11 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uq[i] = dq_side[i][0] ? '1 : dq_q[i];
      if (dq_side[i][1]) begin
        duty_c[i] = (uq[i] >= QUO_BITS'(HALF_Q16 - 1)) ? '0 :
                    17'(HALF_Q16 - 1) - 17'(uq[i]);
      end else begin
        duty_c[i] = (uq[i] > QUO_BITS'(HALF_Q16)) ? 17'(ONE_Q16) :
                    17'(HALF_Q16) + 17'(uq[i]);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else if (en) begin
      v11 <= dq_v[0];
    end
    if (en) begin
      bad11  <= dq_side[0][2];
      duty11 <= duty_c;
    end
  end

  // stage 12: duty times period
  logic [P+16:0] prod [3];
  logic          fin_v;
  res_t          fin;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = (P+17)'(duty11[i]) * (P+17)'(pwm_period);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_v <= 1'b0;
    end else if (en) begin
      fin_v <= v11;
    end
    if (en) begin
      fin.ok <= !bad11;
      fin.u  <= bad11 ? '0 : prod[0][P+15:16];
      fin.v  <= bad11 ? '0 : prod[1][P+15:16];
      fin.w  <= bad11 ? '0 : prod[2][P+15:16];
    end
  end

  // output register with skid
  logic out_v;
  res_t out_r, skid_r;
  logic take;
  assign take = out_v && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (en && fin_v) begin
        if (out_v && !take) begin
          skid_v <= 1'b1;
        end else begin
          out_v <= 1'b1;
        end
      end else if (take) begin
        if (skid_v) begin
          skid_v <= 1'b0;
        end else begin
          out_v <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && fin_v) begin
      if (out_v && !take) begin
        skid_r <= fin;
      end else begin
        out_r <= fin;
      end
    end else if (take && skid_v) begin
      out_r <= skid_r;
    end
  end

  assign m_tvalid   = out_v;
  assign m_tdata    = OUT_W'({out_r.w, out_r.v, out_r.u});
  assign m_tuser[0] = out_r.ok;

  `ASSERT_IMPLIES(a_skid_behind_out, skid_v, out_v)
  `ASSERT_ALWAYS(a_div_lockstep, (dq_v[0] == dq_v[1]) && (dq_v[0] == dq_v[2]))
  `ASSERT_IMPLIES(a_fault_zero, m_tvalid && !m_tuser[0], m_tdata == '0)
  `ASSERT_IMPLIES(a_u_in_period, m_tvalid, m_tdata[P-1:0] <= pwm_period)

endmodule
`default_nettype wire

// ===== src/svpwm_div.sv =====
// pipelined restoring divider, one quotient bit per stage, sideband carried along
// depends on svpwm_pkg; quotient valid only when num < den * 2^QUO_BITS
`default_nettype none
module svpwm_div
  import svpwm_pkg::*;
#(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]    den,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output logic [QUO_BITS-1:0] quo,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int CW = (NUM_W > DEN_W + QUO_BITS) ? NUM_W : DEN_W + QUO_BITS;

  logic [CW-1:0]       rem  [1:QUO_BITS];
  logic [DEN_W-1:0]    dv   [1:QUO_BITS];
  logic [QUO_BITS-1:0] qb   [1:QUO_BITS];
  logic [SIDE_W-1:0]   sd   [1:QUO_BITS];
  logic                vld  [1:QUO_BITS];

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
    localparam int SH = QUO_BITS - 1 - k;
    logic [CW-1:0]       rem_in;
    logic [CW-1:0]       trial;
    logic [DEN_W-1:0]    den_in;
    logic [QUO_BITS-1:0] q_in;
    logic [SIDE_W-1:0]   side_i;
    logic                vld_in;
    logic                take;

    if (k == 0) begin : g_first
      assign rem_in = CW'(num);
      assign den_in = den;
      assign q_in   = '0;
      assign side_i = side_in;
      assign vld_in = in_valid;
    end else begin : g_next
      assign rem_in = rem[k];
      assign den_in = dv[k];
      assign q_in   = qb[k];
      assign side_i = sd[k];
      assign vld_in = vld[k];
    end

    assign trial = CW'(den_in) << SH;
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld_in;
      end
      if (en) begin
        rem[k+1] <= take ? (rem_in - trial) : rem_in;
        dv[k+1]  <= den_in;
        qb[k+1]  <= {q_in[QUO_BITS-2:0], take};
        sd[k+1]  <= side_i;
      end
    end
  end

  assign out_valid = vld[QUO_BITS];
  assign quo       = qb[QUO_BITS];
  assign side_out  = sd[QUO_BITS];

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// testbench for svpwm_duty_generator_core: random and directed alpha/beta/bus requests
// checked against an in-bench duty predictor; depends on svpwm_pkg and the core rtl
`default_nettype none
module tb_top;
  import svpwm_pkg::*;

  localparam int VB = SVPWM_VOLTAGE_BITS;
  localparam int PB = SVPWM_PERIOD_BITS;
  localparam int IN_W = ((3*VB+7)/8)*8;
  localparam int OUT_W = ((3*PB+7)/8)*8;
  localparam int CFG_W = (PB > LIMIT_BITS) ? PB : LIMIT_BITS;
  localparam int LATENCY = VB + 44;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [PB-1:0] w_cmp;
    logic [PB-1:0] v_cmp;
    logic [PB-1:0] u_cmp;
    logic ok;
  } duty_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  int errors = 0;
  longint cycles = 0;
  int n_items = 0;
  int n_checked = 0;
  bit hold_off = 0;
  bit hold_done = 0;

  always #5 clk = ~clk;

  svpwm_duty_generator_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  task automatic report(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  class duty_scoreboard;
    logic [LIMIT_BITS-1:0] mod_limit;
    logic [PB-1:0] period;
    duty_t pending[$];

    function new();
      mod_limit = LIMIT_RESET;
      period = '0;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic longint shrink(longint x, longint unsigned sc);
      longint unsigned m;
      longint r;
      m = (x < 0) ? -x : x;
      r = longint'((m * sc) >> 16);
      return (x < 0) ? -r : r;
    endfunction

    function automatic logic [PB-1:0] phase_count(longint d, longint bus);
      longint den, q, duty;
      longint unsigned prod;
      den = 2 * bus;
      q = d / den;
      if (d % den != 0 && d < 0) q -= 1;
      duty = HALF_Q16 + q;
      if (duty < 0) duty = 0;
      if (duty > ONE_Q16) duty = ONE_Q16;
      prod = (longint'(duty) * longint'(period)) >> 16;
      return prod[PB-1:0];
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      if (idx == REG_MOD_LIMIT) mod_limit = val[LIMIT_BITS-1:0];
      else if (idx == REG_PWM_PERIOD) period = val[PB-1:0];
    endfunction

    function void note_request(logic [IN_W-1:0] data);
      longint a, b, bus, pu, pv, pw, lo, hi;
      longint unsigned mag, vmax, sc;
      duty_t exp_duty;
      a = longint'($signed(data[VB-1:0]));
      b = longint'($signed(data[2*VB-1:VB]));
      bus = longint'(data[3*VB-1:2*VB]);
      exp_duty = '0;
      if (bus >= MIN_BUS && period != 0) begin
        mag = root_floor(a*a + b*b);
        vmax = (((longint'(bus) * longint'(mod_limit)) >> 16) * INV_SQRT3_Q16) >> 16;
        if (mag > vmax) begin
          sc = (vmax << 16) / mag;
          a = shrink(a, sc);
          b = shrink(b, sc);
        end
        pu = a * ONE_Q16;
        pv = -a * HALF_Q16 + b * SQRT3_HALF_Q16;
        pw = -a * HALF_Q16 - b * SQRT3_HALF_Q16;
        lo = pu; hi = pu;
        if (pv < lo) lo = pv;
        if (pw < lo) lo = pw;
        if (pv > hi) hi = pv;
        if (pw > hi) hi = pw;
        exp_duty.u_cmp = phase_count(2*pu - lo - hi, bus);
        exp_duty.v_cmp = phase_count(2*pv - lo - hi, bus);
        exp_duty.w_cmp = phase_count(2*pw - lo - hi, bus);
        exp_duty.ok = 1'b1;
      end
      pending.push_back(exp_duty);
    endfunction

    task check_result(logic [OUT_W-1:0] data, logic okbit);
      duty_t e;
      if (pending.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      e = pending.pop_front();
      if (data[PB-1:0] !== e.u_cmp)
        report($sformatf("u_compare %0d, want %0d", data[PB-1:0], e.u_cmp));
      if (data[2*PB-1:PB] !== e.v_cmp)
        report($sformatf("v_compare %0d, want %0d", data[2*PB-1:PB], e.v_cmp));
      if (data[3*PB-1:2*PB] !== e.w_cmp)
        report($sformatf("w_compare %0d, want %0d", data[3*PB-1:2*PB], e.w_cmp));
      if (okbit !== e.ok)
        report($sformatf("ok %0b, want %0b", okbit, e.ok));
    endtask
  endclass

  duty_scoreboard duty_sb = new();

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sample the input, output and cfg handshakes at the rising edge
  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        duty_sb.note_request(s_tdata);
        n_items++;
      end
      if (m_tvalid && m_tready) begin
        duty_sb.check_result(m_tdata, m_tuser[0]);
        n_checked++;
      end
      if (cfg_valid && cfg_ready) duty_sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off to fill the pipeline
  initial begin
    int g;
    @(negedge clk);
    while (1) begin
      if (hold_off && !hold_done) begin
        m_tready <= 0;
        repeat (300) @(negedge clk);
        hold_done = 1;
      end
      g = gap_len();
      if (g > 0) begin
        m_tready <= 0;
        repeat (g) @(negedge clk);
      end
      m_tready <= 1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  task automatic write_cfg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!(cfg_valid && cfg_ready && !rst && 1'b1) || 0);
    cfg_valid <= 0;
  endtask

  // send one request, holding valid until accepted
  task automatic send_vector(logic [VB-1:0] a, logic [VB-1:0] b, logic [VB-1:0] bus,
                             bit with_gap);
    int g;
    g = with_gap ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= '0;
    s_tdata[3*VB-1:0] <= {bus, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (duty_sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic random_vector(bit with_gap);
    logic [VB-1:0] a, b, bus;
    int k;
    a = VB'($urandom); b = VB'($urandom);
    k = $urandom_range(0, 9);
    if (k < 6) bus = VB'($urandom_range(26, 16000));
    else if (k < 8) bus = VB'($urandom);
    else bus = VB'($urandom_range(0, 30));
    // mostly modest vectors so that both limited and unlimited paths show up
    if ($urandom_range(0, 2) != 0) begin
      a = VB'($signed($urandom_range(0, 8000)) - 4000);
      b = VB'($signed($urandom_range(0, 8000)) - 4000);
    end
    send_vector(a, b, bus, with_gap);
  endtask

  initial begin
    logic [LIMIT_BITS-1:0] limits[5];
    logic [PB-1:0] periods[5];
    int n;
    limits = '{16'd62259, 16'd1, 16'd65535, 16'd32768, 16'd50000};
    periods = '{16'd1000, 16'd65535, 16'd1, 16'd4999, 16'd20000};
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // reset period is zero: every result reports not ok
    send_vector(16'sd100, 16'sd50, 16'd1000, 0);
    send_vector(16'h7fff, 16'h8000, 16'hffff, 0);
    drain();
    write_cfg(REG_PWM_PERIOD, 16'd65535);
    // field extremes, low bus boundary, zero and saturating vectors
    send_vector(16'h0000, 16'h0000, 16'd26, 0);
    send_vector(16'h0000, 16'h0000, 16'd25, 0);
    send_vector(16'h0000, 16'h0000, 16'd0, 0);
    send_vector(16'h7fff, 16'h7fff, 16'hffff, 0);
    send_vector(16'h8000, 16'h8000, 16'hffff, 0);
    send_vector(16'h8000, 16'h7fff, 16'd26, 0);
    send_vector(16'h7fff, 16'h0000, 16'd256, 0);
    send_vector(16'h0000, 16'h8000, 16'd256, 0);
    send_vector(16'd100, 16'd0, 16'd2560, 0);
    send_vector(16'hff00, 16'd300, 16'd2560, 0);
    send_vector(16'hffff, 16'hffff, 16'hffff, 0);
    send_vector(16'h5555, 16'haaaa, 16'haaaa, 0);
    send_vector(16'haaaa, 16'h5555, 16'h5555, 0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_cfg(REG_MOD_LIMIT, limits[ph]);
      write_cfg(REG_PWM_PERIOD, periods[ph]);
      n = 300;
      if (ph == 2) hold_off = 1;
      for (int i = 0; i < n; i++) random_vector(ph != 2 && i > 40);
      drain();
    end
    write_cfg(REG_PWM_PERIOD, 16'd0);
    for (int i = 0; i < 20; i++) random_vector(1);
    drain();

    $display("%0d requests sent, %0d results checked over 5 limit/period settings",
             n_items, n_checked);
    $display("including zero period, low bus and a long output stall");
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
